// File: design/wk_pkg.sv
package wk_pkg;

  // Width of the kurtosis result, unsigned Q12.12
  localparam int unsigned KURT_BITS = 24;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_MUL_WRAP,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_WIN_END,
    ST_FLAT,
    ST_EMIT
  } state_t;

  // Window-end multiply steps, in the order they are run
  typedef enum logic [3:0] {
    STEP_A2,      // a2 = S1 * S1
    STEP_V,       // v  = n * S2 - a2
    STEP_NS4,     // m  = n * S4
    STEP_S1S3,    // m  = m - 4 * S1 * S3
    STEP_MN1,     // m  = m * n
    STEP_S2A2,    // m  = m + 6 * S2 * a2
    STEP_MN2,     // m  = m * n
    STEP_A4,      // m  = m - 3 * a2 * a2
    STEP_D        // d  = v * v
  } step_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  take;
    logic  square;
    logic  accum;
    logic  mul_load;
    logic  mul_run;
    logic  combine;
    logic  div_init;
    logic  div_run;
    logic  win_end;
    logic  flat;
    logic  emit;
    step_t step;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic close;
    logic mul_last;
    logic v_nonpos;
    logic div_skip;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// File: design/wk_ctrl.sv
module wk_ctrl
  import wk_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  // State and step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_A2;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = step_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        step_nxt  = STEP_A2;
        state_nxt = status.close ? ST_MUL_LOAD : ST_EMIT;
      end
      ST_MUL_LOAD: begin
        cmd.mul_load = 1'b1;
        state_nxt    = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        cmd.mul_run = 1'b1;
        if (status.mul_last) state_nxt = ST_MUL_WRAP;
      end
      ST_MUL_WRAP: begin
        cmd.combine = 1'b1;
        if (step_r == STEP_V && status.v_nonpos) begin
          state_nxt = ST_FLAT;
        end else if (step_r == STEP_D) begin
          state_nxt = ST_DIV_INIT;
        end else begin
          step_nxt  = step_t'(step_r + 4'd1);
          state_nxt = ST_MUL_LOAD;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = status.div_skip ? ST_WIN_END : ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_run = 1'b1;
        if (status.div_last) state_nxt = ST_WIN_END;
      end
      ST_WIN_END: begin
        cmd.win_end = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_FLAT: begin
        cmd.flat  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: design/wk_dp.sv
module wk_dp
  import wk_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned WINDOW_BITS   = 12,
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   cfg_wen,
  input  logic [WINDOW_BITS-1:0] cfg_wdata,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KURT_BITS-1:0]   out_kurt,
  output logic                   out_done,
  output logic                   out_flat
);

  localparam int unsigned S1W = SAMPLE_BITS + WINDOW_BITS;
  localparam int unsigned S2W = 2 * SAMPLE_BITS - 1 + WINDOW_BITS;
  localparam int unsigned S3W = 3 * SAMPLE_BITS - 2 + WINDOW_BITS;
  localparam int unsigned S4W = 4 * SAMPLE_BITS - 3 + WINDOW_BITS;
  localparam int unsigned NW  = WINDOW_BITS + 1;
  localparam int unsigned YW  = 2 * (SAMPLE_BITS + WINDOW_BITS);
  localparam int unsigned AW  = 4 * (SAMPLE_BITS + WINDOW_BITS) + KURT_BITS;
  localparam int unsigned MCW = $clog2(YW);
  localparam int unsigned QCW = $clog2(KURT_BITS);
  localparam logic [WINDOW_BITS-1:0] WinReset = WINDOW_BITS'(3000);

  logic        [WINDOW_BITS-1:0]   win_len_r;
  logic signed [SAMPLE_BITS-1:0]   x_r;
  logic signed [2*SAMPLE_BITS-1:0] x2_r;
  logic signed [S1W-1:0]           s1_r;
  logic        [S2W-1:0]           s2_r;
  logic signed [S3W-1:0]           s3_r;
  logic        [S4W-1:0]           s4_r;
  logic        [WINDOW_BITS-1:0]   count_r;
  logic        [NW-1:0]            n_r;
  logic        [KURT_BITS-1:0]     last_k_r;
  logic                            done_r;
  logic                            flat_r;

  logic signed [AW-1:0]  x_mul_r;
  logic signed [YW-1:0]  y_mul_r;
  logic signed [AW-1:0]  acc_r;
  logic        [MCW-1:0] mcnt_r;
  logic        [YW-1:0]  a2_r;
  logic        [YW-1:0]  v_r;
  logic signed [AW-1:0]  m_r;
  logic        [AW-1:0]  d_r;

  logic        [AW-1:0]        rem_r;
  logic        [AW-1:0]        dsh_r;
  logic        [KURT_BITS-1:0] q_r;
  logic        [QCW-1:0]       qcnt_r;

  logic                            out_valid_r;
  logic        [KURT_BITS-1:0]     out_kurt_r;
  logic                            out_done_r;
  logic                            out_flat_r;

  logic        [WINDOW_BITS-1:0]   cnt_inc;
  logic        [2*SAMPLE_BITS-2:0] x2_mag;
  logic signed [3*SAMPLE_BITS-1:0] x3_w;
  logic        [4*SAMPLE_BITS-3:0] x4_w;
  logic signed [AW-1:0]            x_sel;
  logic signed [YW-1:0]            y_sel;
  logic signed [AW-1:0]            v_diff;
  logic        [AW-1:0]            m_shift;
  logic        [AW-1:0]            d_lim;
  logic        [AW-1:0]            rem_sub;

  assign cnt_inc = count_r + WINDOW_BITS'(1);
  // The square is never negative, so its magnitude drops the sign bit.
  assign x2_mag  = x2_r[2*SAMPLE_BITS-2:0];
  assign x3_w    = (3*SAMPLE_BITS)'(x2_r) * (3*SAMPLE_BITS)'(x_r);
  assign x4_w    = {{(2*SAMPLE_BITS-1){1'b0}}, x2_mag} * {{(2*SAMPLE_BITS-1){1'b0}}, x2_mag};
  assign v_diff  = acc_r - $signed({{(AW-YW){1'b0}}, a2_r});
  assign m_shift = AW'(m_r) << FRACTION_BITS;
  assign d_lim   = d_r << KURT_BITS;
  assign rem_sub = rem_r - dsh_r;

  // Status back to the controller
  always_comb begin
    status.close    = (cnt_inc >= win_len_r) || (cnt_inc == '0);
    status.mul_last = (mcnt_r == MCW'(YW - 1));
    status.v_nonpos = v_diff[AW-1] || (v_diff == '0);
    status.div_skip = m_r[AW-1] || (m_shift >= d_lim);
    status.div_last = (qcnt_r == QCW'(KURT_BITS - 1));
    status.out_free = !out_valid_r || out_ready;
  end

  // Multiplier operand selection for each step
  always_comb begin
    unique case (cmd.step)
      STEP_A2: begin
        x_sel = AW'(s1_r);
        y_sel = YW'(s1_r);
      end
      STEP_V: begin
        x_sel = $signed({{(AW-S2W){1'b0}}, s2_r});
        y_sel = $signed({{(YW-NW){1'b0}}, n_r});
      end
      STEP_NS4: begin
        x_sel = $signed({{(AW-S4W){1'b0}}, s4_r});
        y_sel = $signed({{(YW-NW){1'b0}}, n_r});
      end
      STEP_S1S3: begin
        x_sel = AW'(s3_r);
        y_sel = YW'(s1_r);
      end
      STEP_S2A2: begin
        x_sel = $signed({{(AW-S2W){1'b0}}, s2_r});
        y_sel = $signed(a2_r);
      end
      STEP_A4: begin
        x_sel = $signed({{(AW-YW){1'b0}}, a2_r});
        y_sel = $signed(a2_r);
      end
      STEP_D: begin
        x_sel = $signed({{(AW-YW){1'b0}}, v_r});
        y_sel = $signed(v_r);
      end
      default: begin
        x_sel = m_r;
        y_sel = $signed({{(YW-NW){1'b0}}, n_r});
      end
    endcase
  end

  // Window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WinReset;
    end else if (cfg_wen) begin
      win_len_r <= cfg_wdata;
    end
  end

  // Sample capture, squaring and power sums
  always_ff @(posedge clk) begin
    if (cmd.take) x_r <= $signed(sample);
    if (cmd.square) x2_r <= x_r * x_r;
    if (!rst_n) begin
      s1_r     <= '0;
      s2_r     <= '0;
      s3_r     <= '0;
      s4_r     <= '0;
      count_r  <= '0;
      last_k_r <= '0;
      done_r   <= 1'b0;
      flat_r   <= 1'b0;
    end else begin
      if (cmd.take) begin
        done_r <= 1'b0;
        flat_r <= 1'b0;
      end
      if (cmd.accum) begin
        s1_r    <= s1_r + S1W'(x_r);
        s2_r    <= s2_r + S2W'(x2_r);
        s3_r    <= s3_r + S3W'(x3_w);
        s4_r    <= s4_r + S4W'(x4_w);
        count_r <= cnt_inc;
        n_r     <= {(cnt_inc == '0), cnt_inc};
      end
      if (cmd.win_end || cmd.flat) begin
        s1_r     <= '0;
        s2_r     <= '0;
        s3_r     <= '0;
        s4_r     <= '0;
        count_r  <= '0;
        done_r   <= 1'b1;
        flat_r   <= cmd.flat;
        last_k_r <= cmd.flat ? '0 : q_r;
      end
    end
  end

  // Shift-and-add multiplier, one multiplier bit per cycle; the top bit weighs negative
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      x_mul_r <= x_sel;
      y_mul_r <= y_sel;
      acc_r   <= '0;
      mcnt_r  <= '0;
    end else if (cmd.mul_run) begin
      if (y_mul_r[0]) begin
        acc_r <= status.mul_last ? acc_r - x_mul_r : acc_r + x_mul_r;
      end
      x_mul_r <= x_mul_r <<< 1;
      y_mul_r <= y_mul_r >>> 1;
      mcnt_r  <= mcnt_r + MCW'(1);
    end
  end

  // Fold each product into the moment terms
  always_ff @(posedge clk) begin
    if (cmd.combine) begin
      unique case (cmd.step)
        STEP_A2:   a2_r <= YW'(acc_r);
        STEP_V:    v_r  <= YW'(v_diff);
        STEP_NS4:  m_r  <= acc_r;
        STEP_S1S3: m_r  <= m_r - (acc_r <<< 2);
        STEP_MN1:  m_r  <= acc_r;
        STEP_S2A2: m_r  <= m_r + (acc_r <<< 2) + (acc_r <<< 1);
        STEP_MN2:  m_r  <= acc_r;
        STEP_A4:   m_r  <= m_r - (acc_r <<< 1) - acc_r;
        STEP_D:    d_r  <= AW'(acc_r);
        default:   m_r  <= m_r;
      endcase
    end
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= m_shift;
      dsh_r  <= d_r << (KURT_BITS - 1);
      qcnt_r <= '0;
      if (m_r[AW-1]) begin
        q_r <= '0;
      end else if (m_shift >= d_lim) begin
        q_r <= '1;
      end else begin
        q_r <= '0;
      end
    end else if (cmd.div_run) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_sub;
        q_r   <= {q_r[KURT_BITS-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[KURT_BITS-2:0], 1'b0};
      end
      dsh_r  <= dsh_r >> 1;
      qcnt_r <= qcnt_r + QCW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_kurt_r <= last_k_r;
      out_done_r <= done_r;
      out_flat_r <= flat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kurt  = out_kurt_r;
  assign out_done  = out_done_r;
  assign out_flat  = out_flat_r;

endmodule

// File: design/windowed_kurtosis.sv
// A request is accepted only in the idle state. A sample inside a window then passes through
// the square, accumulate and emit states, and its result is registered at the output. A sample
// that closes a window also runs the bit-serial multiply steps and divider (or the flat state).
// A new request is taken only after the last one has been emitted; a result held at the output
// stalls only the request after it.
// Reset (rst_n, synchronous, active low) clears the sums, count and last kurtosis, window 3000.
module windowed_kurtosis
  import wk_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned WINDOW_BITS   = 12,
  parameter int unsigned FRACTION_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // sample
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [KURT_BITS-1:0]                out_tdata,  // kurtosis
  output logic [1:0]                          out_tuser,  // window_done, flat_window
  input  logic                                cfg_wen,
  input  logic [WINDOW_BITS-1:0]              cfg_wdata   // window_length
);

  cmd_t    cmd;
  status_t status;

  wk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wk_dp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .WINDOW_BITS   (WINDOW_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .sample    (in_tdata[SAMPLE_BITS-1:0]),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kurt  (out_tdata),
    .out_done  (out_tuser[0]),
    .out_flat  (out_tuser[1])
  );

endmodule
